// ===== rtl/prt_pkg.sv =====
package prt_pkg;

    // Default for the tile count limit of one request
    localparam int MAX_TILES_DEF = 16;

    // Translation entries the hardware offers at most
    localparam int HW_ENTRIES = 16;

    // Depth of the command queue between the front and back ends
    localparam int CMD_DEPTH = 2;

    localparam int ENTRY_W = 5;

    // Tile sizes by size index: 16M, 64M, 128M, 512M
    localparam logic [29:0] TILE_SIZE [4] = '{
        30'h0100_0000, 30'h0400_0000, 30'h0800_0000, 30'h2000_0000
    };

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_ZERO  = 2'd1;
    localparam logic [1:0] STATUS_NOENT = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } prt_state_t;

    typedef struct packed {
        logic [31:0] phys_base;
        logic [31:0] region_bytes;
        logic [1:0]  largest_size_index;
    } prt_req_t;

    typedef struct packed {
        logic [31:0] tile_base;
        logic [1:0]  tile_size_index;
        logic [29:0] covered_bytes;
        logic        is_last;
        logic [1:0]  status;
        logic [33:0] total_bytes;
        logic [29:0] alignment;
        logic [31:0] va_offset;
    } prt_res_t;

    // Classified request handed from the front end to the back end
    typedef struct packed {
        logic [31:0]        phys_base;
        logic [32:0]        end_addr;
        logic [1:0]         largest_size_index;
        logic [ENTRY_W-1:0] limit;
        logic               zero_size;
    } prt_cmd_t;

endpackage

// ===== rtl/prt_front.sv =====
module prt_front import prt_pkg::*; #(
    parameter int MAX_TILES = MAX_TILES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  prt_req_t           request,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [ENTRY_W-1:0] cfg_data,
    input  logic               q_full,
    output logic               q_wr,
    output prt_cmd_t           q_cmd
);

    localparam int CAP = (MAX_TILES < HW_ENTRIES) ? MAX_TILES : HW_ENTRIES;
    localparam logic [ENTRY_W-1:0] CAP_V = ENTRY_W'(CAP);

    logic [ENTRY_W-1:0] entries_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= ENTRY_W'(HW_ENTRIES);
        end
        else if (cfg_valid && cfg_ready)
        begin
            entries_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign full      = q_full;
    assign q_wr      = push && !q_full;

    // Classify: exact end in 33 bits, tile budget, zero length
    always_comb
    begin
        q_cmd.phys_base          = request.phys_base;
        q_cmd.end_addr           = {1'b0, request.phys_base} + {1'b0, request.region_bytes};
        q_cmd.largest_size_index = request.largest_size_index;
        q_cmd.limit              = (entries_reg > CAP_V) ? CAP_V : entries_reg;
        q_cmd.zero_size          = (request.region_bytes == 32'd0);
    end

endmodule

// ===== rtl/prt_cmd_fifo.sv =====
module prt_cmd_fifo import prt_pkg::*; #(
    parameter int DEPTH = CMD_DEPTH
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  prt_cmd_t wr_cmd,
    output logic     full,
    input  logic     rd_en,
    output prt_cmd_t rd_cmd,
    output logic     empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    prt_cmd_t        mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_wr;
    logic            do_rd;

    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_cmd = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// ===== rtl/prt_back.sv =====
module prt_back import prt_pkg::*; #(
    parameter int MAX_TILES = MAX_TILES_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_empty,
    input  prt_cmd_t q_cmd,
    output logic     q_rd,
    output logic     empty,
    input  logic     pop,
    output prt_res_t result
);

    localparam int CAP = (MAX_TILES < HW_ENTRIES) ? MAX_TILES : HW_ENTRIES;
    localparam int CW  = $clog2(CAP + 1);

    prt_state_t  state_reg, state_next;
    logic        out_valid_reg;
    prt_res_t    out_reg;
    logic [CW-1:0] used_reg;
    logic [32:0] phys_reg;
    logic [32:0] end_reg;
    logic [1:0]  maxi_reg;
    logic [CW-1:0] limit_reg;
    logic        zero_reg;
    logic [33:0] total_reg;
    logic [29:0] align_reg;
    logic [31:0] voff_reg;

    logic [33:0] ts_a  [4];
    logic [33:0] te_a  [4];
    logic [33:0] lim_a [4];
    logic [29:0] cov_a [4];
    logic [29:0] best;
    logic [1:0]  bi;
    logic [29:0] tsz;
    logic [32:0] phys_adv;
    logic        tile_last;
    logic [33:0] total_adv;
    logic        grow;
    logic [29:0] align_adv;
    logic [31:0] voff_adv;

    logic        can_emit;
    logic        emit;
    logic        take_tile;
    logic        done;
    prt_res_t    res_next;

    // Candidate tile for each size
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            ts_a[i]  = {1'b0, phys_reg} & ~({4'b0, TILE_SIZE[i]} - 34'd1);
            te_a[i]  = ts_a[i] + {4'b0, TILE_SIZE[i]};
            lim_a[i] = ({1'b0, end_reg} < te_a[i]) ? {1'b0, end_reg} : te_a[i];
            cov_a[i] = 30'(lim_a[i] - {1'b0, phys_reg});
        end
    end

    // Greedy pick: grow only if more is covered and under half is wasted
    always_comb
    begin
        best = '0;
        bi   = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (2'(i) <= maxi_reg && cov_a[i] > best &&
                !(best != '0 && cov_a[i] <= (TILE_SIZE[i] >> 1)))
            begin
                best = cov_a[i];
                bi   = 2'(i);
            end
        end
    end

    always_comb
    begin
        tsz       = TILE_SIZE[bi];
        phys_adv  = phys_reg + {3'b0, best};
        tile_last = (phys_adv >= end_reg);
        total_adv = total_reg + {4'b0, tsz};
        grow      = (tsz > align_reg);
        align_adv = grow ? tsz : align_reg;
        voff_adv  = (grow && total_reg != '0) ? ({2'b0, tsz} - total_reg[31:0]) : voff_reg;
    end

    assign can_emit = !out_valid_reg || pop;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        q_rd      = 1'b0;
        emit      = 1'b0;
        take_tile = 1'b0;
        res_next  = '0;
        case (state_reg)
            ST_IDLE:
            begin
                q_rd = !q_empty;
            end
            ST_RUN:
            begin
                emit = can_emit;
                if (zero_reg)
                begin
                    res_next.is_last = 1'b1;
                    res_next.status  = STATUS_ZERO;
                end
                else if (used_reg >= limit_reg)
                begin
                    res_next.is_last     = 1'b1;
                    res_next.status      = STATUS_NOENT;
                    res_next.total_bytes = total_reg;
                    res_next.alignment   = align_reg;
                    res_next.va_offset   = voff_reg;
                end
                else
                begin
                    take_tile                = can_emit;
                    res_next.tile_base       = ts_a[bi][31:0];
                    res_next.tile_size_index = bi;
                    res_next.covered_bytes   = best;
                    res_next.is_last         = tile_last;
                    res_next.status          = STATUS_OK;
                    res_next.total_bytes     = total_adv;
                    res_next.alignment       = align_adv;
                    res_next.va_offset       = voff_adv;
                end
            end
            default:
            begin
                q_rd = 1'b0;
            end
        endcase
    end

    assign done = emit && res_next.is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            used_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
            if (q_rd)
            begin
                used_reg <= '0;
            end
            else if (take_tile)
            begin
                used_reg <= used_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= res_next;
        end
        if (q_rd)
        begin
            phys_reg  <= {1'b0, q_cmd.phys_base};
            end_reg   <= q_cmd.end_addr;
            maxi_reg  <= q_cmd.largest_size_index;
            limit_reg <= CW'(q_cmd.limit);
            zero_reg  <= q_cmd.zero_size;
            total_reg <= '0;
            align_reg <= '0;
            voff_reg  <= '0;
        end
        else if (take_tile)
        begin
            phys_reg  <= phys_adv;
            total_reg <= total_adv;
            align_reg <= align_adv;
            voff_reg  <= voff_adv;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    a_tile_budget: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> used_reg <= limit_reg)
        else $error("tile count passed its budget");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_rd |-> (state_reg == ST_IDLE && !q_empty))
        else $error("command taken outside idle");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && res_next.status != STATUS_OK) |-> res_next.is_last)
        else $error("error result not marked last");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> state_reg == ST_IDLE)
        else $error("sequencer kept running after last result");

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |-> !emit)
        else $error("result overwritten before transfer");

endmodule

// ===== rtl/pmb_region_tiler.sv =====
// Channel   | Handshake               | Payload
// ----------+-------------------------+-----------------------------------------
// request   | push / full             | prt_req_t: base, byte count, size cap
// result    | pop / empty             | prt_res_t: one tile, totals on the last
// config    | cfg_valid / cfg_ready   | cfg_data: free translation entries
//
// A request is loaded into the tile sequencer from its idle state; the sequencer then
// issues one result per cycle while the result register has room.
// Reset is asynchronous and active low; it empties the command queue and the
// result register and sets the entry budget to 16.
// A result left waiting stalls the back end first; the front end keeps taking
// requests until the two-entry command queue is full, then raises full.
module pmb_region_tiler import prt_pkg::*; #(
    parameter int MAX_TILES = MAX_TILES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // request queue side
    input  logic               push,
    output logic               full,
    input  prt_req_t           request,
    // result queue side
    output logic               empty,
    input  logic               pop,
    output prt_res_t           result,
    // entry budget register
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [ENTRY_W-1:0] cfg_data
);

    logic     q_full;
    logic     q_wr;
    prt_cmd_t q_wr_cmd;
    logic     q_empty;
    logic     q_rd;
    prt_cmd_t q_rd_cmd;

    // Front end: hold the entry budget, compute the exact end, classify
    prt_front #(
        .MAX_TILES (MAX_TILES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_wr      (q_wr),
        .q_cmd     (q_wr_cmd)
    );

    // Command queue: decouple accept from tile generation
    prt_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_wr),
        .wr_cmd (q_wr_cmd),
        .full   (q_full),
        .rd_en  (q_rd),
        .rd_cmd (q_rd_cmd),
        .empty  (q_empty)
    );

    // Back end: advance one tile per cycle into the result register while it has room
    prt_back #(
        .MAX_TILES (MAX_TILES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_cmd   (q_rd_cmd),
        .q_rd    (q_rd),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

// ===== tb/sv/prt_tile_check.sv =====
module prt_tile_check import prt_pkg::*; #(
    parameter int MAX_TILES = MAX_TILES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  prt_req_t           request,
    input  logic               empty,
    input  logic               pop,
    input  prt_res_t           result,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [ENTRY_W-1:0] cfg_data,
    output int                 mismatches,
    output int                 results_due
);

    logic [ENTRY_W-1:0] entry_budget;
    prt_res_t           tile_plan[$];
    prt_res_t           oldest_tile;
    int                 fail_total = 0;

    assign mismatches = fail_total;

    // Cover one request with tiles and queue the results it must produce.
    function automatic void plan_request(prt_req_t req);
        logic [33:0] cursor;
        logic [33:0] region_end;
        logic [33:0] sz;
        logic [33:0] ts;
        logic [33:0] te;
        logic [33:0] cov;
        logic [33:0] best;
        logic [33:0] chosen;
        logic [33:0] total;
        logic [33:0] align;
        logic [33:0] voff;
        int          budget;
        int          used;
        int          i;
        logic [1:0]  pick;
        prt_res_t    tile;

        cursor     = {2'b00, req.phys_base};
        region_end = cursor + {2'b00, req.region_bytes};
        budget     = int'(entry_budget);
        if (budget > HW_ENTRIES)
            budget = HW_ENTRIES;
        if (budget > MAX_TILES)
            budget = MAX_TILES;
        total = '0;
        align = '0;
        voff  = '0;
        used  = 0;

        if (req.region_bytes == '0)
        begin
            tile         = '0;
            tile.is_last = 1'b1;
            tile.status  = STATUS_ZERO;
            tile_plan.push_back(tile);
            return;
        end

        while (cursor < region_end)
        begin
            if (used >= budget)
            begin
                tile             = '0;
                tile.is_last     = 1'b1;
                tile.status      = STATUS_NOENT;
                tile.total_bytes = total;
                tile.alignment   = align[29:0];
                tile.va_offset   = voff[31:0];
                tile_plan.push_back(tile);
                return;
            end
            used++;

            // Try sizes from the smallest up; drop a larger one that adds nothing
            // or wastes half or more of its tile.
            best = '0;
            pick = '0;
            for (i = 0; i <= int'(req.largest_size_index); i++)
            begin
                sz  = {4'b0000, TILE_SIZE[i]};
                ts  = cursor & ~(sz - 34'd1);
                te  = ts + sz;
                cov = ((region_end < te) ? region_end : te) - cursor;
                if (cov <= best)
                    continue;
                if (best != '0 && (sz - cov) >= (sz >> 1))
                    continue;
                pick = i[1:0];
                best = cov;
            end

            chosen = {4'b0000, TILE_SIZE[pick]};
            ts     = cursor & ~(chosen - 34'd1);
            if (chosen > align)
            begin
                align = chosen;
                if (total != '0)
                    voff = align - total;
            end
            total  = total + chosen;
            cursor = cursor + best;

            tile.tile_base       = ts[31:0];
            tile.tile_size_index = pick;
            tile.covered_bytes   = best[29:0];
            tile.is_last         = (cursor >= region_end);
            tile.status          = STATUS_OK;
            tile.total_bytes     = total;
            tile.alignment       = align[29:0];
            tile.va_offset       = voff[31:0];
            tile_plan.push_back(tile);
        end
    endfunction

    function automatic void report_field(string name, logic [33:0] want, logic [33:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_total++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_budget = ENTRY_W'(HW_ENTRIES);
            tile_plan.delete();
        end
        else
        begin
            if (pop && !empty)
            begin
                if (tile_plan.size() == 0)
                begin
                    $display("%0t: unexpected result transfer, expected none, actual %h",
                             $time, result);
                    fail_total++;
                end
                else
                begin
                    oldest_tile = tile_plan.pop_front();
                    report_field("tile_base", 34'(oldest_tile.tile_base), 34'(result.tile_base));
                    report_field("tile_size_index", 34'(oldest_tile.tile_size_index),
                                 34'(result.tile_size_index));
                    report_field("covered_bytes", 34'(oldest_tile.covered_bytes),
                                 34'(result.covered_bytes));
                    report_field("is_last", 34'(oldest_tile.is_last), 34'(result.is_last));
                    report_field("status", 34'(oldest_tile.status), 34'(result.status));
                    report_field("total_bytes", oldest_tile.total_bytes, result.total_bytes);
                    report_field("alignment", 34'(oldest_tile.alignment), 34'(result.alignment));
                    report_field("va_offset", 34'(oldest_tile.va_offset),
                                 34'(result.va_offset));
                end
            end
            if (push && !full)
                plan_request(request);
            if (cfg_valid && cfg_ready)
                entry_budget = cfg_data;
        end
        results_due = tile_plan.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
    import prt_pkg::*;

    // Longest correct quiet stretch is the receiver's long hold-off; allow
    // several times that before calling the run hung.
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int PHASE_ITEMS      = 78;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               push      = 1'b0;
    logic               full;
    prt_req_t           request   = '0;
    logic               empty;
    logic               pop       = 1'b0;
    prt_res_t           result;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [ENTRY_W-1:0] cfg_data  = '0;

    int mismatches;
    int results_due;
    int quiet_cycles = 0;
    int burst_left   = 0;
    bit hold_request = 1'b0;  // ask the receiver for one long hold-off
    bit steady_send  = 1'b0;  // suppress sender gaps

    always #1 clk = ~clk;

    pmb_region_tiler uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    prt_tile_check tile_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .request     (request),
        .empty       (empty),
        .pop         (pop),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .results_due (results_due)
    );

    function automatic prt_req_t make_req(logic [31:0] base, logic [31:0] bytes, logic [1:0] cap);
        prt_req_t req;
        req.phys_base          = base;
        req.region_bytes       = bytes;
        req.largest_size_index = cap;
        return req;
    endfunction

    // Mostly regions that tile within the budget, at all scales; a few zero
    // sizes and full-range sizes that run out of entries.
    function automatic prt_req_t random_req();
        prt_req_t req;
        int       shape;
        shape                  = $urandom_range(0, 19);
        req.largest_size_index = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
            0, 1:    req.phys_base = $urandom;
            2:       req.phys_base = $urandom & 32'hFF00_0000;
            default: req.phys_base = $urandom | 32'hF000_0000;
        endcase
        if (shape == 0)
            req.region_bytes = '0;
        else if (shape < 8)
            req.region_bytes = $urandom_range(1, 32'h0200_0000);
        else if (shape < 15)
            req.region_bytes = $urandom_range(1, 32'h2000_0000);
        else if (shape < 18)
            req.region_bytes = $urandom_range(1, 32'h8000_0000);
        else
            req.region_bytes = $urandom;
        return req;
    endfunction

    // Offer one request; every call starts and ends on a falling edge.
    // Hold push high across a burst, drop it for the gap between bursts.
    task automatic offer_request(prt_req_t req);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = (steady_send || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        push    <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (full);
        @(negedge clk);
    endtask

    // Drain the block, then write the entry budget.
    task automatic write_entry_budget(logic [ENTRY_W-1:0] budget);
        push       <= 1'b0;
        burst_left  = 0;
        while (results_due != 0)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= budget;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(logic [ENTRY_W-1:0] budget, bit with_pressure);
        int n;
        write_entry_budget(budget);
        if (with_pressure)
        begin
            // Hold the result side off while requests keep coming, so the
            // command queue fills and full must stall the sender.
            hold_request = 1'b1;
            steady_send  = 1'b1;
            for (n = 0; n < 12; n++)
                offer_request(random_req());
            steady_send = 1'b0;
        end
        for (n = 0; n < PHASE_ITEMS; n++)
            offer_request(random_req());
    endtask

    // Receiver: stall in modes of random length, plus one long hold-off on request.
    initial
    begin
        int mode;
        int span;
        int beat;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 64);
            for (beat = 0; beat < span; beat++)
            begin
                @(negedge clk);
                if (hold_request)
                begin
                    hold_request = 1'b0;
                    pop <= 1'b0;
                    repeat (LONG_HOLD_CYCLES) @(negedge clk);
                end
                case (mode)
                    0:       pop <= 1'b1;
                    1:       pop <= 1'($urandom_range(0, 1));
                    2:       pop <= ($urandom_range(0, 4) == 0);
                    default: pop <= ((beat % 8) < 5);
                endcase
            end
        end
    end

    // Watchdog: count cycles with no transfer on any channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed requests at the reset budget of 16 entries.
        offer_request(make_req(32'h1234_5678, 32'h0000_0000, 2'd3));  // zero size
        offer_request(make_req(32'h0000_0000, 32'h0000_0001, 2'd0));
        offer_request(make_req(32'h0000_0000, 32'h2000_0000, 2'd3));  // one whole 512M tile
        offer_request(make_req(32'h00FF_FFFF, 32'h0000_0002, 2'd3));  // straddles 16M line
        offer_request(make_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3));  // runs past 4G
        offer_request(make_req(32'h0000_0000, 32'hFFFF_FFFF, 2'd0));  // out of entries
        offer_request(make_req(32'h0400_0000, 32'h0400_0000, 2'd1));
        offer_request(make_req(32'h0800_0000, 32'h0800_0000, 2'd2));
        offer_request(make_req(32'h0780_0000, 32'h0300_0000, 2'd2));  // half-waste rule
        offer_request(make_req(32'h1000_0000, 32'h0200_0000, 2'd3));  // larger adds nothing
        offer_request(make_req(32'hE000_0000, 32'h4000_0000, 2'd3));  // tile base wraps
        offer_request(make_req(32'h0100_0000, 32'h0C00_0000, 2'd1));
        offer_request(make_req(32'hAAAA_AAAA, 32'h5555_5555, 2'd2));
        offer_request(make_req(32'h5555_5555, 32'hAAAA_AAAA, 2'd1));

        // No entries: every nonzero request ends at once.
        write_entry_budget(5'd0);
        offer_request(make_req(32'h0000_0000, 32'h0000_0000, 2'd0));
        offer_request(make_req(32'h2000_0000, 32'h0100_0000, 2'd3));

        // One entry: a single tile fits, a second one does not.
        write_entry_budget(5'd1);
        offer_request(make_req(32'h0100_0000, 32'h0100_0000, 2'd0));
        offer_request(make_req(32'h0180_0000, 32'h0100_0000, 2'd0));

        // Budget above the hardware limit saturates at 16.
        write_entry_budget(5'd31);
        offer_request(make_req(32'h0000_0000, 32'h2000_0000, 2'd0));

        random_phase(5'd31, 1'b1);
        random_phase(5'd3, 1'b0);
        random_phase(5'd16, 1'b0);
        random_phase(5'($urandom_range(0, 31)), 1'b0);

        // Drain, then allow a sequencer pass for stray results.
        push <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (MAX_TILES_DEF + 4) @(negedge clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== pmb_region_tiler.f =====
rtl/prt_pkg.sv
rtl/prt_front.sv
rtl/prt_cmd_fifo.sv
rtl/prt_back.sv
rtl/pmb_region_tiler.sv
tb/sv/prt_tile_check.sv
tb/sv/tb_top.sv
